>>> sv/gso_pkg.sv
// Shared constants and types for the 3x3 Gram-Schmidt orthonormalizer.
package gso_pkg;

  localparam int NORM_BITS = 19;
  localparam int MAG_W     = NORM_BITS;
  localparam int VEC_W     = NORM_BITS + 1;
  localparam int RES_W     = 24;
  localparam int COEF_Q    = 22;
  localparam int LEN_Q     = 10;
  localparam int K_W       = 25;
  localparam int PROD_W    = 2 * VEC_W;
  localparam int DOT_W     = PROD_W + 2;
  localparam int SQ_W      = 2 * VEC_W;
  localparam int ROOT_W    = (SQ_W + 2 * LEN_Q) / 2;
  localparam int PROJ_LAT  = K_W + 5;

  localparam int DEF_COMPONENT_WIDTH = 18;
  localparam int DEF_FRAC_BITS       = 16;

  typedef logic signed [VEC_W-1:0] comp_t;
  typedef logic signed [RES_W-1:0] res_t;

endpackage

>>> sv/gram_schmidt_orthonormalize_3x3.sv
// Throughput: one transaction per cycle; every stage advances together unless
// a finished result is held by result_stall.
// Depth is set by the bit-per-stage dividers (projection coefficients, unit
// scaling) and the bit-per-stage square root.
// Synchronous reset clears the valid bits only; no clearing pass.
module gram_schmidt_orthonormalize_3x3
  import gso_pkg::*;
#(
  parameter int COMPONENT_WIDTH = DEF_COMPONENT_WIDTH,
  parameter int FRAC_BITS       = DEF_FRAC_BITS
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              valid,
  output logic                              stall,
  input  logic signed [COMPONENT_WIDTH-1:0] first_x,
  input  logic signed [COMPONENT_WIDTH-1:0] first_y,
  input  logic signed [COMPONENT_WIDTH-1:0] first_z,
  input  logic signed [COMPONENT_WIDTH-1:0] second_x,
  input  logic signed [COMPONENT_WIDTH-1:0] second_y,
  input  logic signed [COMPONENT_WIDTH-1:0] second_z,
  input  logic signed [COMPONENT_WIDTH-1:0] third_x,
  input  logic signed [COMPONENT_WIDTH-1:0] third_y,
  input  logic signed [COMPONENT_WIDTH-1:0] third_z,
  output logic                              result_valid,
  input  logic                              result_stall,
  output logic signed [COMPONENT_WIDTH-1:0] unit_a_x,
  output logic signed [COMPONENT_WIDTH-1:0] unit_a_y,
  output logic signed [COMPONENT_WIDTH-1:0] unit_a_z,
  output logic signed [COMPONENT_WIDTH-1:0] unit_b_x,
  output logic signed [COMPONENT_WIDTH-1:0] unit_b_y,
  output logic signed [COMPONENT_WIDTH-1:0] unit_b_z,
  output logic signed [COMPONENT_WIDTH-1:0] unit_c_x,
  output logic signed [COMPONENT_WIDTH-1:0] unit_c_y,
  output logic signed [COMPONENT_WIDTH-1:0] unit_c_z,
  output logic                              degenerate
);

  localparam int CW   = COMPONENT_WIDTH;
  localparam int LP   = PROJ_LAT;
  localparam int LU   = FRAC_BITS + ROOT_W + 5;
  localparam int LAT  = 2 * LP + LU + 4;
  localparam int VW   = 3 * VEC_W;

  logic                 en;
  logic [LAT-1:0]       vld;

  logic signed [CW-1:0] va [3];
  logic signed [CW-1:0] vb [3];
  logic signed [CW-1:0] vc [3];
  comp_t                as [3];
  comp_t                bs [3];
  comp_t                cs [3];
  res_t                 bs_r [3];
  res_t                 cs_r [3];
  res_t                 bres [3];
  res_t                 r1 [3];
  res_t                 r1d [3];
  res_t                 r2 [3];
  comp_t                bn [3];
  comp_t                cn [3];
  comp_t                cs_d [3];
  comp_t                as_d [3];
  comp_t                bn_d [3];
  logic                 ok_a;
  logic                 ok_b;
  logic                 ok_c;
  logic                 ok_a_d;
  logic                 ok_ab_d;
  logic                 ok_all;
  logic                 ok_out;
  logic [VW-1:0]        cs_p;
  logic [VW-1:0]        cs_pd;
  logic [VW-1:0]        as_p;
  logic [VW-1:0]        as_pd;
  logic [VW-1:0]        bn_p;
  logic [VW-1:0]        bn_pd;
  logic [3*RES_W-1:0]   r1_p;
  logic [3*RES_W-1:0]   r1_pd;
  logic signed [CW-1:0] ua [3];
  logic signed [CW-1:0] ub [3];
  logic signed [CW-1:0] uc [3];

  assign en    = !(result_valid && result_stall);
  assign stall = !en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], valid};
    end
  end

  assign result_valid = vld[LAT-1];

  assign va[0] = first_x;
  assign va[1] = first_y;
  assign va[2] = first_z;
  assign vb[0] = second_x;
  assign vb[1] = second_y;
  assign vb[2] = second_z;
  assign vc[0] = third_x;
  assign vc[1] = third_y;
  assign vc[2] = third_z;

  gso_norm #(.IW(CW)) u_norm_a (
    .clk (clk), .en (en), .vin (va), .vout (as), .nonzero (ok_a)
  );

  gso_norm #(.IW(CW)) u_norm_b (
    .clk (clk), .en (en), .vin (vb), .vout (bs), .nonzero ()
  );

  gso_norm #(.IW(CW)) u_norm_c (
    .clk (clk), .en (en), .vin (vc), .vout (cs), .nonzero ()
  );

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      bs_r[i]                   = res_t'(bs[i]);
      cs_r[i]                   = res_t'(cs[i]);
      cs_p[i*VEC_W +: VEC_W]    = cs[i];
      as_p[i*VEC_W +: VEC_W]    = as[i];
      bn_p[i*VEC_W +: VEC_W]    = bn[i];
      r1_p[i*RES_W +: RES_W]    = r1[i];
      cs_d[i]                   = cs_pd[i*VEC_W +: VEC_W];
      as_d[i]                   = as_pd[i*VEC_W +: VEC_W];
      bn_d[i]                   = bn_pd[i*VEC_W +: VEC_W];
      r1d[i]                    = r1_pd[i*RES_W +: RES_W];
    end
  end

  gso_proj u_proj_ba (
    .clk (clk), .en (en), .base (as), .vec (bs), .res_in (bs_r), .res_out (bres)
  );

  gso_proj u_proj_ca (
    .clk (clk), .en (en), .base (as), .vec (cs), .res_in (cs_r), .res_out (r1)
  );

  gso_norm #(.IW(RES_W)) u_norm_bres (
    .clk (clk), .en (en), .vin (bres), .vout (bn), .nonzero (ok_b)
  );

  gso_delay #(.W(3 * RES_W), .N(1)) u_r1_dly (
    .clk (clk), .en (en), .din (r1_p), .dout (r1_pd)
  );

  gso_delay #(.W(VW), .N(LP + 1)) u_cs_dly (
    .clk (clk), .en (en), .din (cs_p), .dout (cs_pd)
  );

  gso_proj u_proj_cb (
    .clk (clk), .en (en), .base (bn), .vec (cs_d), .res_in (r1d), .res_out (r2)
  );

  gso_norm #(.IW(RES_W)) u_norm_cres (
    .clk (clk), .en (en), .vin (r2), .vout (cn), .nonzero (ok_c)
  );

  gso_delay #(.W(VW), .N(2 * LP + 2)) u_as_dly (
    .clk (clk), .en (en), .din (as_p), .dout (as_pd)
  );

  gso_delay #(.W(VW), .N(LP + 1)) u_bn_dly (
    .clk (clk), .en (en), .din (bn_p), .dout (bn_pd)
  );

  gso_delay #(.W(1), .N(LP + 1)) u_oka_dly (
    .clk (clk), .en (en), .din (ok_a), .dout (ok_a_d)
  );

  gso_delay #(.W(1), .N(LP + 1)) u_okab_dly (
    .clk (clk), .en (en), .din (ok_a_d & ok_b), .dout (ok_ab_d)
  );

  assign ok_all = ok_ab_d & ok_c;

  gso_delay #(.W(1), .N(LU)) u_ok_dly (
    .clk (clk), .en (en), .din (ok_all), .dout (ok_out)
  );

  gso_unit #(.CW(CW), .FRAC(FRAC_BITS)) u_unit_a (
    .clk (clk), .en (en), .vec (as_d), .q (ua)
  );

  gso_unit #(.CW(CW), .FRAC(FRAC_BITS)) u_unit_b (
    .clk (clk), .en (en), .vec (bn_d), .q (ub)
  );

  gso_unit #(.CW(CW), .FRAC(FRAC_BITS)) u_unit_c (
    .clk (clk), .en (en), .vec (cn), .q (uc)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      unit_a_x   <= ok_out ? ua[0] : '0;
      unit_a_y   <= ok_out ? ua[1] : '0;
      unit_a_z   <= ok_out ? ua[2] : '0;
      unit_b_x   <= ok_out ? ub[0] : '0;
      unit_b_y   <= ok_out ? ub[1] : '0;
      unit_b_z   <= ok_out ? ub[2] : '0;
      unit_c_x   <= ok_out ? uc[0] : '0;
      unit_c_y   <= ok_out ? uc[1] : '0;
      unit_c_z   <= ok_out ? uc[2] : '0;
      degenerate <= !ok_out;
    end
  end

`ifndef NO_ASSERTIONS
  a_degenerate_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && degenerate |->
      unit_a_x == 0 && unit_a_y == 0 && unit_a_z == 0 &&
      unit_b_x == 0 && unit_b_y == 0 && unit_b_z == 0 &&
      unit_c_x == 0 && unit_c_y == 0 && unit_c_z == 0)
    else $error("degenerate transaction with nonzero vector");

  a_blocked_input: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |-> stall)
    else $error("input taken while pipeline is frozen");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid right after reset");
`endif

endmodule

>>> sv/gso_delay.sv
// Enabled shift-register delay line.
module gso_delay #(
  parameter int W = 1,
  parameter int N = 1
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] din,
  output logic [W-1:0] dout
);

  logic [W-1:0] tap [N];

  always_ff @(posedge clk) begin
    if (en) begin
      tap[0] <= din;
      for (int i = 1; i < N; i++) begin
        tap[i] <= tap[i-1];
      end
    end
  end

  assign dout = tap[N-1];

endmodule

>>> sv/gso_div.sv
// Pipelined restoring divider, one quotient bit per stage.
module gso_div #(
  parameter int NW = 64,
  parameter int DW = 42,
  parameter int QW = 25
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [QW-1:0] quo
);

  localparam int W = (NW > DW + QW) ? NW : DW + QW;

  logic [W-1:0]  rem [1:QW];
  logic [DW-1:0] dsr [1:QW];
  logic [QW-1:0] qq  [1:QW];

  for (genvar i = 0; i < QW; i++) begin : g_stage
    logic [W-1:0]  rc;
    logic [DW-1:0] dc;
    logic [QW-1:0] qc;
    logic [W-1:0]  trial;
    logic          take;
    if (i == 0) begin : g_first
      assign rc = W'(num);
      assign dc = den;
      assign qc = '0;
    end else begin : g_next
      assign rc = rem[i];
      assign dc = dsr[i];
      assign qc = qq[i];
    end
    assign trial = W'(dc) << (QW - 1 - i);
    assign take  = rc >= trial;
    always_ff @(posedge clk) begin
      if (en) begin
        rem[i+1] <= take ? rc - trial : rc;
        dsr[i+1] <= dc;
        qq[i+1]  <= {qc[QW-2:0], take};
      end
    end
  end

  assign quo = qq[QW];

endmodule

>>> sv/gso_sqrt.sv
// Pipelined integer square root, one root bit per stage.
module gso_sqrt #(
  parameter int RW = 30
) (
  input  logic            clk,
  input  logic            en,
  input  logic [2*RW-1:0] rad,
  output logic [RW-1:0]   root
);

  localparam int NW = 2 * RW;

  logic [NW-1:0] rem [1:RW];
  logic [RW-1:0] rt  [1:RW];

  for (genvar i = 0; i < RW; i++) begin : g_step
    logic [NW-1:0] rc;
    logic [RW-1:0] tc;
    logic [NW-1:0] cand;
    logic          take;
    if (i == 0) begin : g_first
      assign rc = rad;
      assign tc = '0;
    end else begin : g_next
      assign rc = rem[i];
      assign tc = rt[i];
    end
    assign cand = (NW'(tc) << (RW - i)) | (NW'(1) << (2 * (RW - 1 - i)));
    assign take = rc >= cand;
    always_ff @(posedge clk) begin
      if (en) begin
        rem[i+1] <= take ? rc - cand : rc;
        rt[i+1]  <= take ? (tc | (RW'(1) << (RW - 1 - i))) : tc;
      end
    end
  end

  assign root = rt[RW];

endmodule

>>> sv/gso_norm.sv
// Block scaling: shifts a vector so its largest magnitude has NORM_BITS bits.
module gso_norm
  import gso_pkg::*;
#(
  parameter int IW = RES_W
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [IW-1:0] vin [3],
  output comp_t                vout [3],
  output logic                 nonzero
);

  localparam int LW = $clog2(IW + 1);
  localparam int EW = IW + NORM_BITS;

  logic [IW-1:0]        mag [3];
  logic [IW-1:0]        any_bits;
  logic [LW-1:0]        len;
  logic [EW-1:0]        ext [3];
  comp_t                scl [3];

  always_comb begin
    any_bits = '0;
    for (int i = 0; i < 3; i++) begin
      mag[i]   = vin[i][IW-1] ? (~vin[i]) + IW'(1) : vin[i];
      any_bits = any_bits | mag[i];
    end
    len = '0;
    for (int j = 0; j < IW; j++) begin
      if (any_bits[j]) begin
        len = LW'(j + 1);
      end
    end
    for (int i = 0; i < 3; i++) begin
      ext[i] = {mag[i], {NORM_BITS{1'b0}}} >> len;
      scl[i] = comp_t'({1'b0, ext[i][NORM_BITS-1:0]});
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        vout[i] <= vin[i][IW-1] ? -scl[i] : scl[i];
      end
      nonzero <= |any_bits;
    end
  end

endmodule

>>> sv/gso_proj.sv
// Projection removal: res_out = res_in - k*base, k = dot(vec,base)/dot(base,base).
module gso_proj
  import gso_pkg::*;
(
  input  logic  clk,
  input  logic  en,
  input  comp_t base [3],
  input  comp_t vec [3],
  input  res_t  res_in [3],
  output res_t  res_out [3]
);

  localparam int NUM_W  = DOT_W - 2 + COEF_Q + 2;
  localparam int PM_W   = K_W + MAG_W;
  localparam int TERM_W = PM_W + 1 - COEF_Q;
  localparam int BW     = 3 * (MAG_W + 1);

  logic signed [PROD_W-1:0] pd [3];
  logic signed [PROD_W-1:0] pn [3];
  logic signed [DOT_W-1:0]  d;
  logic [DOT_W-1:0]         nn;
  logic [DOT_W-1:0]         dmag;
  logic [NUM_W-1:0]         num;
  logic [DOT_W-1:0]         den;
  logic                     dneg;
  logic                     dneg_d;
  logic [K_W-1:0]           k;
  logic [BW-1:0]            bpack;
  logic [BW-1:0]            bpack_d;
  logic [3*RES_W-1:0]       rpack;
  logic [3*RES_W-1:0]       rpack_d;
  logic [PM_W-1:0]          pm [3];
  logic                     tneg [3];
  logic [PM_W:0]            pr [3];
  logic [TERM_W-1:0]        term [3];
  res_t                     rd [3];
  logic [MAG_W-1:0]         bm [3];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        pd[i] <= PROD_W'(vec[i]) * PROD_W'(base[i]);
        pn[i] <= PROD_W'(base[i]) * PROD_W'(base[i]);
      end
      d    <= DOT_W'(pd[0]) + DOT_W'(pd[1]) + DOT_W'(pd[2]);
      nn   <= DOT_W'(pn[0]) + DOT_W'(pn[1]) + DOT_W'(pn[2]);
      num  <= NUM_W'({dmag[DOT_W-3:0], {(COEF_Q + 1){1'b0}}}) + NUM_W'(nn);
      den  <= {nn[DOT_W-2:0], 1'b0};
      dneg <= d[DOT_W-1];
    end
  end

  assign dmag = d[DOT_W-1] ? DOT_W'(-d) : DOT_W'(d);

  gso_div #(.NW(NUM_W), .DW(DOT_W), .QW(K_W)) u_div (
    .clk (clk),
    .en  (en),
    .num (num),
    .den (den),
    .quo (k)
  );

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      bm[i] = MAG_W'(base[i][VEC_W-1] ? -base[i] : base[i]);
      bpack[i*(MAG_W+1) +: MAG_W+1] = {base[i][VEC_W-1], bm[i]};
      rpack[i*RES_W +: RES_W]       = res_in[i];
    end
  end

  gso_delay #(.W(BW), .N(3 + K_W)) u_bdly (
    .clk (clk), .en (en), .din (bpack), .dout (bpack_d)
  );

  gso_delay #(.W(1), .N(K_W)) u_sdly (
    .clk (clk), .en (en), .din (dneg), .dout (dneg_d)
  );

  gso_delay #(.W(3 * RES_W), .N(4 + K_W)) u_rdly (
    .clk (clk), .en (en), .din (rpack), .dout (rpack_d)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        pm[i]   <= PM_W'(k) * PM_W'(bpack_d[i*(MAG_W+1) +: MAG_W]);
        tneg[i] <= dneg_d ^ bpack_d[i*(MAG_W+1) + MAG_W];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pr[i]   = {1'b0, pm[i]} + ((PM_W + 1)'(1) << (COEF_Q - 1));
      term[i] = pr[i][PM_W:COEF_Q];
      rd[i]   = rpack_d[i*RES_W +: RES_W];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        res_out[i] <= tneg[i] ? rd[i] + res_t'(term[i]) : rd[i] - res_t'(term[i]);
      end
    end
  end

endmodule

>>> sv/gso_unit.sv
// Unit-length scaling: length by square root, then one rounded divide per component.
module gso_unit
  import gso_pkg::*;
#(
  parameter int CW   = DEF_COMPONENT_WIDTH,
  parameter int FRAC = DEF_FRAC_BITS
) (
  input  logic                 clk,
  input  logic                 en,
  input  comp_t                vec [3],
  output logic signed [CW-1:0] q [3]
);

  localparam int NUM_W = MAG_W + FRAC + LEN_Q + 2;
  localparam int DEN_W = ROOT_W + 1;
  localparam int QW    = FRAC + 1;
  localparam int EW    = ((QW > CW) ? QW : CW) + 1;
  localparam int MW    = 3 * MAG_W;

  logic signed [PROD_W-1:0] sq [3];
  logic [SQ_W-1:0]          ss;
  logic [ROOT_W-1:0]        len;
  logic [MW-1:0]            mpack;
  logic [MW-1:0]            mpack_d;
  logic [2:0]               negs;
  logic [2:0]               negs_d;
  logic [NUM_W-1:0]         num [3];
  logic [DEN_W-1:0]         den;
  logic [QW-1:0]            quo [3];
  logic [EW-1:0]            qz [3];
  logic [EW-1:0]            lim;
  logic signed [CW-1:0]     hi;
  logic signed [CW-1:0]     lo;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        sq[i] <= PROD_W'(vec[i]) * PROD_W'(vec[i]);
      end
      ss <= SQ_W'(sq[0]) + SQ_W'(sq[1]) + SQ_W'(sq[2]);
    end
  end

  gso_sqrt #(.RW(ROOT_W)) u_sqrt (
    .clk  (clk),
    .en   (en),
    .rad  ({ss, {(2 * LEN_Q){1'b0}}}),
    .root (len)
  );

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mpack[i*MAG_W +: MAG_W] = MAG_W'(vec[i][VEC_W-1] ? -vec[i] : vec[i]);
      negs[i]                 = vec[i][VEC_W-1];
    end
  end

  gso_delay #(.W(MW), .N(2 + ROOT_W)) u_mdly (
    .clk (clk), .en (en), .din (mpack), .dout (mpack_d)
  );

  gso_delay #(.W(3), .N(3 + ROOT_W + QW)) u_ndly (
    .clk (clk), .en (en), .din (negs), .dout (negs_d)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        num[i] <= NUM_W'({mpack_d[i*MAG_W +: MAG_W], {(FRAC + LEN_Q + 1){1'b0}}})
                  + NUM_W'(len);
      end
      den <= {len, 1'b0};
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_div
    gso_div #(.NW(NUM_W), .DW(DEN_W), .QW(QW)) u_div (
      .clk (clk),
      .en  (en),
      .num (num[i]),
      .den (den),
      .quo (quo[i])
    );
  end

  assign lim = EW'(1) << (CW - 1);
  assign hi  = {1'b0, {(CW - 1){1'b1}}};
  assign lo  = {1'b1, {(CW - 1){1'b0}}};

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      qz[i] = EW'(quo[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        if (negs_d[i]) begin
          q[i] <= (qz[i] > lim) ? lo : CW'(EW'(0) - qz[i]);
        end else begin
          q[i] <= (qz[i] >= lim) ? hi : CW'(qz[i]);
        end
      end
    end
  end

endmodule

>>> test/gram_schmidt_orthonormalize_3x3_tb.sv
// Testbench for the 3x3 Gram-Schmidt orthonormalizer: directed and random vector sets.
`timescale 1ns / 1ps

module gram_schmidt_orthonormalize_3x3_tb
  import gso_pkg::*;
;

  localparam int CW   = DEF_COMPONENT_WIDTH;
  localparam int FB   = DEF_FRAC_BITS;
  localparam int NB   = NORM_BITS;
  localparam int CQ   = COEF_Q;
  localparam int LQ   = LEN_Q;
  localparam int LAT  = 2 * (K_W + 5) + FB + ROOT_W + 9;
  localparam logic signed [CW-1:0] MAXV = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] MINV = {1'b1, {(CW-1){1'b0}}};

  typedef logic signed [CW-1:0] fld_t;
  typedef longint vec3_t [3];

  typedef struct packed {
    fld_t ax, ay, az, bx, by, bz, cx, cy, cz;
    logic degen;
  } ortho_t;

  logic clk = 0;
  logic rst = 1;
  logic valid = 0;
  logic result_stall = 0;
  fld_t first_x = 0, first_y = 0, first_z = 0;
  fld_t second_x = 0, second_y = 0, second_z = 0;
  fld_t third_x = 0, third_y = 0, third_z = 0;
  logic stall, result_valid, degenerate;
  fld_t unit_a_x, unit_a_y, unit_a_z, unit_b_x, unit_b_y, unit_b_z;
  fld_t unit_c_x, unit_c_y, unit_c_z;

  ortho_t expected_bases[$];
  int     errors = 0;
  int     send_idle_pct = 0;
  int     recv_idle_pct = 0;

  gram_schmidt_orthonormalize_3x3 u_top (.*);

  always #2 clk = ~clk;

  function automatic longint umag(longint x);
    return x < 0 ? -x : x;
  endfunction

  function automatic longint rdiv(longint num, longint den);
    longint m;
    m = (2 * umag(num) + den) / (2 * den);
    return num < 0 ? -m : m;
  endfunction

  function automatic bit normalize_block(ref vec3_t v);
    longint mx, m;
    int len;
    mx = 0;
    len = 0;
    for (int i = 0; i < 3; i++) if (umag(v[i]) > mx) mx = umag(v[i]);
    if (mx == 0) return 0;
    while ((mx >> len) != 0) len++;
    for (int i = 0; i < 3; i++) begin
      m = umag(v[i]);
      if (len > NB) m = m >> (len - NB);
      else m = m << (NB - len);
      v[i] = v[i] < 0 ? -m : m;
    end
    return 1;
  endfunction

  function automatic longint dot(vec3_t u, vec3_t v);
    return u[0] * v[0] + u[1] * v[1] + u[2] * v[2];
  endfunction

  function automatic void subtract_proj(ref vec3_t r, input vec3_t base, input vec3_t v);
    longint d, nn, k, sh;
    d = dot(v, base);
    nn = dot(base, base);
    sh = umag(d) << CQ;
    k = rdiv(d < 0 ? -sh : sh, nn);
    for (int i = 0; i < 3; i++) r[i] -= rdiv(k * base[i], 64'sd1 << CQ);
  endfunction

  function automatic longint isqrt(longint unsigned n);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic void unit_vec(vec3_t v, output fld_t o0, output fld_t o1, output fld_t o2);
    longint len, m, q;
    fld_t o[3];
    len = isqrt(longint'(dot(v, v)) << (2 * LQ));
    for (int i = 0; i < 3; i++) begin
      m = umag(v[i]) << (FB + LQ);
      q = (2 * m + len) / (2 * len);
      if (v[i] < 0) q = -q;
      if (q > longint'(MAXV)) q = MAXV;
      if (q < longint'(MINV)) q = MINV;
      o[i] = q[CW-1:0];
    end
    o0 = o[0];
    o1 = o[1];
    o2 = o[2];
  endfunction

  function automatic ortho_t orthonormalize(fld_t in[9]);
    vec3_t a, b, c, r;
    bit ok;
    ortho_t res;
    for (int i = 0; i < 3; i++) begin
      a[i] = in[i];
      b[i] = in[3 + i];
      c[i] = in[6 + i];
    end
    res = '0;
    ok = normalize_block(a);
    if (ok) begin
      void'(normalize_block(b));
      subtract_proj(b, a, b);
      ok = normalize_block(b);
    end
    if (ok) begin
      void'(normalize_block(c));
      r = c;
      subtract_proj(r, a, c);
      subtract_proj(r, b, c);
      ok = normalize_block(r);
    end
    if (!ok) begin
      res.degen = 1;
      return res;
    end
    unit_vec(a, res.ax, res.ay, res.az);
    unit_vec(b, res.bx, res.by, res.bz);
    unit_vec(r, res.cx, res.cy, res.cz);
    return res;
  endfunction

  task automatic send_vectors(fld_t in[9]);
    while ($urandom_range(99) < send_idle_pct) begin
      valid <= 0;
      @(posedge clk);
    end
    valid <= 1;
    {first_x, first_y, first_z} <= {in[0], in[1], in[2]};
    {second_x, second_y, second_z} <= {in[3], in[4], in[5]};
    {third_x, third_y, third_z} <= {in[6], in[7], in[8]};
    @(posedge clk);
    while (stall) @(posedge clk);
    expected_bases.push_back(orthonormalize(in));
  endtask

  function automatic fld_t rand_comp(int mode);
    case (mode)
      0: return fld_t'($urandom);
      1: return fld_t'($urandom_range(16) - 8);
      2: return $urandom_range(1) ? MAXV : MINV;
      default: return fld_t'($signed($urandom) >>> $urandom_range(31));
    endcase
  endfunction

  task automatic test_directed();
    fld_t v[9];
    v = '{default: 0};
    send_vectors(v);
    v = '{MAXV, 0, 0, 0, MAXV, 0, 0, 0, MAXV};
    send_vectors(v);
    v = '{MINV, MINV, MINV, MAXV, MAXV, MAXV, MINV, 0, MAXV};
    send_vectors(v);
    v = '{1, 0, 0, 2, 0, 0, 0, 0, 1};
    send_vectors(v);
    v = '{1, 2, 3, 2, 4, 6, 5, 1, 0};
    send_vectors(v);
    v = '{1, 2, 3, 4, 5, 6, 7, 8, 9};
    send_vectors(v);
    v = '{1000, 1, 0, 1000, 2, 0, 3, 5, 7};
    send_vectors(v);
    v = '{65536, 0, 0, 0, 65536, 0, 0, 0, 65536};
    send_vectors(v);
    v = '{MINV, 0, 0, 0, MINV, 0, 0, 0, MINV};
    send_vectors(v);
    v = '{1, 1, 1, -1, -1, -1, 1, -1, 0};
    send_vectors(v);
    v = '{-1, 0, 0, 0, -1, 0, 0, 0, -1};
    send_vectors(v);
    v = '{MAXV, 1, -1, MAXV, 0, 1, MAXV, -1, 0};
    send_vectors(v);
  endtask

  task automatic test_random(int count);
    fld_t v[9];
    int mode;
    for (int n = 0; n < count; n++) begin
      mode = $urandom_range(9);
      for (int i = 0; i < 9; i++)
        v[i] = rand_comp(mode < 5 ? 0 : mode < 7 ? 3 : mode < 9 ? 1 : 2);
      if ($urandom_range(19) == 0)
        for (int i = 0; i < 3; i++) v[3 + i] = v[i] * $signed($urandom_range(2) - 1);
      if ($urandom_range(19) == 0)
        for (int i = 0; i < 3; i++) v[6 + i] = v[i] + v[3 + i];
      send_vectors(v);
    end
  endtask

  always @(posedge clk) begin
    if (!rst) result_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  always @(posedge clk) begin
    ortho_t e;
    if (!rst && result_valid && !result_stall) begin
      if (expected_bases.size() == 0) begin
        $error("unexpected transaction");
        errors++;
      end else begin
        e = expected_bases.pop_front();
        if (unit_a_x !== e.ax) begin $error("unit_a_x exp %0d got %0d", e.ax, unit_a_x); errors++; end
        if (unit_a_y !== e.ay) begin $error("unit_a_y exp %0d got %0d", e.ay, unit_a_y); errors++; end
        if (unit_a_z !== e.az) begin $error("unit_a_z exp %0d got %0d", e.az, unit_a_z); errors++; end
        if (unit_b_x !== e.bx) begin $error("unit_b_x exp %0d got %0d", e.bx, unit_b_x); errors++; end
        if (unit_b_y !== e.by) begin $error("unit_b_y exp %0d got %0d", e.by, unit_b_y); errors++; end
        if (unit_b_z !== e.bz) begin $error("unit_b_z exp %0d got %0d", e.bz, unit_b_z); errors++; end
        if (unit_c_x !== e.cx) begin $error("unit_c_x exp %0d got %0d", e.cx, unit_c_x); errors++; end
        if (unit_c_y !== e.cy) begin $error("unit_c_y exp %0d got %0d", e.cy, unit_c_y); errors++; end
        if (unit_c_z !== e.cz) begin $error("unit_c_z exp %0d got %0d", e.cz, unit_c_z); errors++; end
        if (degenerate !== e.degen) begin
          $error("degenerate exp %0d got %0d", e.degen, degenerate);
          errors++;
        end
      end
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst <= 0;
    send_idle_pct = 24;
    recv_idle_pct = 49;
    test_directed();
    test_random(330);
    send_idle_pct = 49;
    recv_idle_pct = 24;
    test_random(330);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(340);
    valid <= 0;
    while (expected_bases.size() != 0) @(posedge clk);
    repeat (LAT + 20) @(posedge clk);
    if (errors == 0 && expected_bases.size() == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

  initial begin
    #2000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
